// ----- sv/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// shared codes and control types for the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

	// request codes on req_type
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// status codes on the result beat
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// fixed widths of the result fields
	localparam int unsigned OUT_TAG_W = 32;
	localparam int unsigned OUT_POS_W = 6;
	localparam int unsigned OUT_OCC_W = 7;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} spq_ctl_t;

endpackage
`default_nettype wire

// ----- sv/spq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: compares against the pushed priority and
// either holds, loads the new entry, takes its left neighbour or its right
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int unsigned PRIO_BITS = 16,
	parameter int unsigned TAG_BITS  = 32
) (
	input  wire                         clk,
	input  wire spq_pkg::spq_ctl_t      ctl,
	input  wire logic signed [PRIO_BITS-1:0] new_prio,
	input  wire logic [TAG_BITS-1:0]    new_tag,
	input  wire logic                   occupied,
	input  wire logic                   left_ge,
	input  wire logic signed [PRIO_BITS-1:0] left_prio,
	input  wire logic [TAG_BITS-1:0]    left_tag,
	input  wire logic signed [PRIO_BITS-1:0] right_prio,
	input  wire logic [TAG_BITS-1:0]    right_tag,
	output logic signed [PRIO_BITS-1:0] prio,
	output logic [TAG_BITS-1:0]         tag,
	output logic                        ge
);
	import spq_pkg::*;

	logic signed [PRIO_BITS-1:0] prio_q;
	logic [TAG_BITS-1:0]         tag_q;

	// held entry stays ahead of an equal or lower new priority
	assign ge   = occupied && (prio_q >= new_prio);
	assign prio = prio_q;
	assign tag  = tag_q;

	// slot update: hold, insert, shift towards tail, or shift towards head
	always_ff @(posedge clk) begin
		if (ctl.push && !ge) begin
			if (left_ge) begin
				prio_q <= new_prio;
				tag_q  <= new_tag;
			end else begin
				prio_q <= left_prio;
				tag_q  <= left_tag;
			end
		end else if (ctl.pop) begin
			prio_q <= right_prio;
			tag_q  <= right_tag;
		end
	end

endmodule
`default_nettype wire

// ----- sv/stable_priority_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue, highest priority first, arrival order among equals
// ----------------------------------------------------------------------------
// output: the result beat appears in the output register in the cycle after
//   the request beat is accepted
// throughput: one request per cycle unless a held result beat stalls the input, set by
//   the row of cells that compares and shifts every slot in the same cycle
// reset: clears the occupancy count and the output valid; slot contents are
//   not cleared and are only read below the count
module stable_priority_queue #(
	parameter int unsigned CAPACITY  = 64,
	parameter int unsigned PRIO_BITS = 16,
	parameter int unsigned TAG_BITS  = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [1:0]              req_type,
	input  wire logic signed [PRIO_BITS-1:0] priority_req,
	input  wire logic [TAG_BITS-1:0]     data_tag,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [1:0]                   status,
	output logic [spq_pkg::OUT_POS_W-1:0] insert_position,
	output logic [spq_pkg::OUT_TAG_W-1:0] popped_tag,
	output logic                         popped_valid,
	output logic [spq_pkg::OUT_OCC_W-1:0] occupancy,
	output logic [spq_pkg::OUT_TAG_W-1:0] head_tag,
	output logic                         head_valid
);
	import spq_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned POS_W = $clog2(CAPACITY);

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;

	logic signed [PRIO_BITS-1:0] prio_w [CAPACITY];
	logic [TAG_BITS-1:0]         tag_w  [CAPACITY];
	logic [CAPACITY-1:0]         ge_w;
	logic [CAPACITY-1:0]         boundary;

	logic             accept;
	logic             full;
	logic             empty;
	spq_ctl_t         ctl;
	logic [1:0]       status_d;
	logic [POS_W-1:0] pos_d;
	logic             popped_valid_d;
	logic [CNT_W-1:0] count_d;
	logic [TAG_BITS-1:0] head_d;

	// handshake: stall only while a finished beat is still held
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                        occ;
		logic                        lge;
		logic signed [PRIO_BITS-1:0] lprio;
		logic [TAG_BITS-1:0]         ltag;
		logic signed [PRIO_BITS-1:0] rprio;
		logic [TAG_BITS-1:0]         rtag;

		assign occ = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_head
			assign lge   = 1'b1;
			assign lprio = priority_req;
			assign ltag  = data_tag;
		end else begin : g_mid
			assign lge   = ge_w[i-1];
			assign lprio = prio_w[i-1];
			assign ltag  = tag_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign rprio = prio_w[i];
			assign rtag  = tag_w[i];
		end else begin : g_body
			assign rprio = prio_w[i+1];
			assign rtag  = tag_w[i+1];
		end
		assign boundary[i] = lge && !ge_w[i];

		spq_cell #(
			.PRIO_BITS(PRIO_BITS),
			.TAG_BITS (TAG_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_prio  (priority_req),
			.new_tag   (data_tag),
			.occupied  (occ),
			.left_ge   (lge),
			.left_prio (lprio),
			.left_tag  (ltag),
			.right_prio(rprio),
			.right_tag (rtag),
			.prio      (prio_w[i]),
			.tag       (tag_w[i]),
			.ge        (ge_w[i])
		);
	end

	// insert position: encode the single boundary between kept and shifted
	always_comb begin
		pos_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (boundary[i]) pos_d = pos_d | POS_W'(i);
		end
	end

	// request decode and next count
	always_comb begin
		ctl            = '0;
		status_d       = ST_OK;
		popped_valid_d = 1'b0;
		count_d        = count_q;
		case (req_type)
			OP_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.push = accept;
					count_d  = count_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					ctl.pop        = accept;
					popped_valid_d = 1'b1;
					count_d        = count_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// head entry as it stands after the step
	always_comb begin
		if (count_d == '0) begin
			head_d = '0;
		end else if (ctl.push && boundary[0]) begin
			head_d = data_tag;
		end else if (ctl.pop) begin
			head_d = tag_w[1];
		end else begin
			head_d = tag_w[0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (accept) begin
			status          <= status_d;
			insert_position <= ctl.push ? OUT_POS_W'(pos_d) : '0;
			popped_tag      <= popped_valid_d ? OUT_TAG_W'(tag_w[0]) : '0;
			popped_valid    <= popped_valid_d;
			occupancy       <= OUT_OCC_W'(count_d);
			head_tag        <= OUT_TAG_W'(head_d);
			head_valid      <= (count_d != '0);
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// count stays within the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("occupancy count beyond capacity");

	// sorted row has exactly one insert boundary while space remains
	a_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> $onehot(boundary))
		else $error("insert boundary not unique");

	// accepted push into free space grows the count by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == OP_PUSH && !full) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not grow the count");

	// reported head agrees with reported occupancy
	a_head_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (head_valid == (occupancy != '0)))
		else $error("head valid disagrees with occupancy");
`endif

endmodule
`default_nettype wire
